[design/gms_pkg.sv]
package gms_pkg;

    localparam int unsigned W_WIDTH = 17;
    localparam int unsigned W_TARGET = 18;
    localparam int unsigned W_FORCE = 15;
    localparam int unsigned W_FLIMIT = 16;
    localparam int unsigned W_TICKS = 12;
    localparam int unsigned W_CODE = 3;
    localparam int unsigned W_CFG_INDEX = 2;

    localparam int unsigned MOVE_TICKS = 2048;
    localparam int unsigned MAX_WIDTH_UM = 110000;

    localparam logic [W_WIDTH-1:0] INNER_RESET = '0;
    localparam logic [W_WIDTH-1:0] OUTER_RESET = W_WIDTH'(110000);
    localparam logic [W_FLIMIT-1:0] FLIMIT_RESET = W_FLIMIT'(500);

    // Exact floor(d / MOVE_TICKS) for any d below 2**W_WIDTH by multiplying with a
    // rounded-up reciprocal and shifting.
    localparam int unsigned DIV_L = $clog2(MOVE_TICKS);
    localparam int unsigned DIV_SHIFT = W_WIDTH + DIV_L;
    localparam int unsigned W_RECIP = W_WIDTH + 1;
    localparam longint unsigned DIV_RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(MOVE_TICKS) - 64'd1) / 64'(MOVE_TICKS);
    localparam logic [W_RECIP-1:0] DIV_RECIP = W_RECIP'(DIV_RECIP_FULL);

    typedef enum logic [W_CODE-1:0] {
        REQ_TICK     = 3'd0,
        REQ_HOMING   = 3'd1,
        REQ_PREPOS   = 3'd2,
        REQ_GRASP    = 3'd3,
        REQ_RELEASE  = 3'd4,
        REQ_STOP     = 3'd5,
        REQ_PARTLOST = 3'd6,
        REQ_ESTOP    = 3'd7
    } req_t;

    typedef enum logic [W_CODE-1:0] {
        ST_OK     = 3'd0,
        ST_DENIED = 3'd1,
        ST_NOINIT = 3'd2,
        ST_RANGE  = 3'd3,
        ST_FAILED = 3'd4
    } status_t;

    typedef enum logic [W_CODE-1:0] {
        GS_IDLE        = 3'd0,
        GS_POSITIONING = 3'd1,
        GS_GRASPING    = 3'd2,
        GS_RELEASING   = 3'd3,
        GS_HOLDING     = 3'd4,
        GS_PART_LOST   = 3'd5,
        GS_NO_PART     = 3'd6
    } gstate_t;

    typedef enum logic [W_CFG_INDEX-1:0] {
        CFG_INNER  = 2'd0,
        CFG_OUTER  = 2'd1,
        CFG_FLIMIT = 2'd2
    } cfg_index_t;

endpackage

[design/gripper_motion_sequencer.sv]
// Two-finger gripper sequencer: takes one request per cycle (tick, homing,
// preposition, grasp, release, stop, part lost, set emergency stop) while the
// output is not stalled, and returns one result per request with status, grasp
// state, opening width, force and busy. A request is captured in an input
// register and its effect is applied when it moves on into the single update
// stage that writes the sequencer state, where its result is loaded. Input
// ready drops only while a result waits unclaimed and the input register is
// full. During a move each tick advances the width along a linear ramp of
// MOVE_TICKS ticks; the ramp step is derived once at move start by a
// reciprocal multiply, and each tick adds it with a remainder carry.
// Configuration writes are always ready and must happen while idle.
module gripper_motion_sequencer
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [gms_pkg::W_CODE-1:0]            req_type,
    input  logic                                  open_direction,
    input  logic                                  relative_move,
    input  logic signed [gms_pkg::W_TARGET-1:0]   target_width,
    input  logic                                  estop_level,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [gms_pkg::W_CODE-1:0]            status,
    output logic [gms_pkg::W_CODE-1:0]            grasp_state,
    output logic [gms_pkg::W_WIDTH-1:0]           opening_width,
    output logic [gms_pkg::W_FORCE-1:0]           grip_force,
    output logic                                  busy_res,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gms_pkg::W_CFG_INDEX-1:0]       cfg_index,
    input  logic [gms_pkg::W_WIDTH-1:0]           cfg_data
);

    localparam int unsigned WW = gms_pkg::W_WIDTH;
    localparam int unsigned WT = gms_pkg::W_TICKS;
    localparam int unsigned W_PROD = WW + gms_pkg::W_RECIP;
    localparam int unsigned W_QM = WW + WT;

    // Configuration
    logic [WW-1:0]                  inner_reg;
    logic [WW-1:0]                  outer_reg;
    logic [gms_pkg::W_FLIMIT-1:0]   flimit_reg;

    // Input register
    logic                           s1_valid_reg;
    gms_pkg::req_t                  req_reg;
    logic                           open_reg;
    logic                           rel_reg;
    logic signed [gms_pkg::W_TARGET-1:0] tw_reg;
    logic                           lvl_reg;

    logic                           out_valid_reg;
    logic                           advance;

    // Sequencer state
    logic                           estop_reg, estop_next;
    logic                           homed_reg, homed_next;
    logic                           nopart_reg, nopart_next;
    logic                           moving_reg, moving_next;
    gms_pkg::status_t               status_reg, status_next;
    gms_pkg::gstate_t               state_reg, state_next;
    logic [WW-1:0]                  goal_reg, goal_next;
    logic [WW-1:0]                  start_reg, start_next;
    logic [WW-1:0]                  width_reg, width_next;
    logic [gms_pkg::W_FORCE-1:0]    force_reg, force_next;
    logic [WT-1:0]                  elapsed_reg, elapsed_next;
    logic [WW-1:0]                  dist_reg, dist_next;
    logic [WW-1:0]                  step_reg, step_next;
    logic [WW-1:0]                  prog_reg, prog_next;
    logic [WT-1:0]                  rem_reg, rem_next;
    logic                           down_reg, down_next;

    // Move setup
    logic signed [WW+1:0]           new_width;
    logic                           range_bad;
    logic [WW-1:0]                  home_goal;
    logic [WW-1:0]                  mv_goal;
    logic                           mv_down;
    logic [WW-1:0]                  mv_dist;
    logic [W_PROD-1:0]              mv_prod;
    logic [W_PROD-1:0]              mv_quot;

    // Ramp step
    logic [WT:0]                    elapsed_inc;
    logic [W_QM-1:0]                step_mul;
    logic [WT-1:0]                  step_rem;
    logic [WT:0]                    rem_sum;
    logic                           rem_carry;
    logic [WT:0]                    rem_adj;
    logic [WW-1:0]                  prog_inc;
    logic [WW-1:0]                  ramp_width;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign grasp_state   = state_reg;
    assign opening_width = width_reg;
    assign grip_force    = force_reg;
    assign busy_res      = moving_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg  <= gms_pkg::INNER_RESET;
            outer_reg  <= gms_pkg::OUTER_RESET;
            flimit_reg <= gms_pkg::FLIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (gms_pkg::cfg_index_t'(cfg_index))
                gms_pkg::CFG_INNER:  inner_reg  <= cfg_data;
                gms_pkg::CFG_OUTER:  outer_reg  <= cfg_data;
                gms_pkg::CFG_FLIMIT: flimit_reg <= cfg_data[gms_pkg::W_FLIMIT-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg  <= gms_pkg::req_t'(req_type);
            open_reg <= open_direction;
            rel_reg  <= relative_move;
            tw_reg   <= target_width;
            lvl_reg  <= estop_level;
        end
    end

    // Move setup: goal, direction, distance and per-tick step
    always_comb
    begin
        if ((req_reg == gms_pkg::REQ_PREPOS) && rel_reg)
        begin
            new_width = $signed({2'b00, width_reg}) + (WW+2)'(tw_reg);
        end
        else
        begin
            new_width = (WW+2)'(tw_reg);
        end
        range_bad = (new_width > $signed({2'b00, outer_reg}))
                 || (new_width < $signed({2'b00, inner_reg}));

        home_goal = open_reg ? WW'(gms_pkg::MAX_WIDTH_UM) : '0;
        if (home_goal < inner_reg)
        begin
            home_goal = inner_reg;
        end
        if (home_goal > outer_reg)
        begin
            home_goal = outer_reg;
        end

        mv_goal = (req_reg == gms_pkg::REQ_HOMING) ? home_goal : new_width[WW-1:0];
        mv_down = mv_goal < width_reg;
        mv_dist = mv_down ? (width_reg - mv_goal) : (mv_goal - width_reg);
        mv_prod = W_PROD'(mv_dist) * W_PROD'(gms_pkg::DIV_RECIP);
        mv_quot = mv_prod >> gms_pkg::DIV_SHIFT;
    end

    // Ramp: progress = floor(dist * elapsed / MOVE_TICKS), kept as quotient plus remainder
    always_comb
    begin
        elapsed_inc = {1'b0, elapsed_reg} + (WT+1)'(1);
        step_mul    = W_QM'(step_reg) * W_QM'(gms_pkg::MOVE_TICKS);
        step_rem    = WT'(dist_reg - step_mul[WW-1:0]);
        rem_sum     = {1'b0, rem_reg} + {1'b0, step_rem};
        rem_carry   = rem_sum >= (WT+1)'(gms_pkg::MOVE_TICKS);
        rem_adj     = rem_carry ? (rem_sum - (WT+1)'(gms_pkg::MOVE_TICKS)) : rem_sum;
        prog_inc    = prog_reg + step_reg + WW'(rem_carry);
        ramp_width  = down_reg ? (start_reg - prog_inc) : (start_reg + prog_inc);
    end

    always_comb
    begin
        estop_next   = estop_reg;
        homed_next   = homed_reg;
        nopart_next  = nopart_reg;
        moving_next  = moving_reg;
        status_next  = status_reg;
        state_next   = state_reg;
        goal_next    = goal_reg;
        start_next   = start_reg;
        width_next   = width_reg;
        force_next   = force_reg;
        elapsed_next = elapsed_reg;
        dist_next    = dist_reg;
        step_next    = step_reg;
        prog_next    = prog_reg;
        rem_next     = rem_reg;
        down_next    = down_reg;

        case (req_reg)
            gms_pkg::REQ_TICK:
            begin
                if (moving_reg && (status_reg == gms_pkg::ST_OK))
                begin
                    elapsed_next = elapsed_inc[WT-1:0];
                    if (elapsed_inc >= (WT+1)'(gms_pkg::MOVE_TICKS))
                    begin
                        width_next  = goal_reg;
                        moving_next = 1'b0;
                        if (estop_reg)
                        begin
                            status_next = gms_pkg::ST_DENIED;
                            state_next  = gms_pkg::GS_IDLE;
                        end
                        else if (state_reg == gms_pkg::GS_GRASPING)
                        begin
                            if (nopart_reg)
                            begin
                                status_next = gms_pkg::ST_FAILED;
                                state_next  = gms_pkg::GS_NO_PART;
                            end
                            else
                            begin
                                state_next = gms_pkg::GS_HOLDING;
                            end
                        end
                        else
                        begin
                            state_next = gms_pkg::GS_IDLE;
                        end
                    end
                    else
                    begin
                        prog_next  = prog_inc;
                        rem_next   = rem_adj[WT-1:0];
                        width_next = ramp_width;
                    end
                end
            end
            gms_pkg::REQ_HOMING,
            gms_pkg::REQ_PREPOS,
            gms_pkg::REQ_GRASP,
            gms_pkg::REQ_RELEASE:
            begin
                if (estop_reg)
                begin
                    status_next = gms_pkg::ST_DENIED;
                end
                else if ((req_reg != gms_pkg::REQ_HOMING) && !homed_reg)
                begin
                    status_next = gms_pkg::ST_NOINIT;
                end
                else if ((req_reg != gms_pkg::REQ_HOMING) && range_bad)
                begin
                    status_next = gms_pkg::ST_RANGE;
                end
                else
                begin
                    // restart the ramp from the present width
                    goal_next    = mv_goal;
                    start_next   = width_reg;
                    force_next   = '0;
                    state_next   = gms_pkg::GS_POSITIONING;
                    status_next  = gms_pkg::ST_OK;
                    elapsed_next = '0;
                    moving_next  = 1'b1;
                    dist_next    = mv_dist;
                    step_next    = mv_quot[WW-1:0];
                    prog_next    = '0;
                    rem_next     = '0;
                    down_next    = mv_down;
                    if (req_reg == gms_pkg::REQ_HOMING)
                    begin
                        homed_next = 1'b1;
                    end
                    else
                    begin
                        nopart_next = 1'b0;
                    end
                    if (req_reg == gms_pkg::REQ_GRASP)
                    begin
                        force_next = flimit_reg[gms_pkg::W_FLIMIT-1:1];
                        state_next = gms_pkg::GS_GRASPING;
                    end
                    else if (req_reg == gms_pkg::REQ_RELEASE)
                    begin
                        state_next = gms_pkg::GS_RELEASING;
                    end
                end
            end
            gms_pkg::REQ_STOP:
            begin
                status_next = gms_pkg::ST_OK;
                moving_next = 1'b0;
            end
            gms_pkg::REQ_PARTLOST:
            begin
                nopart_next = 1'b1;
                if (state_reg == gms_pkg::GS_HOLDING)
                begin
                    state_next = gms_pkg::GS_PART_LOST;
                end
            end
            gms_pkg::REQ_ESTOP:
            begin
                estop_next = lvl_reg;
            end
            default:
            begin
                estop_next = estop_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            estop_reg   <= 1'b0;
            homed_reg   <= 1'b0;
            nopart_reg  <= 1'b0;
            moving_reg  <= 1'b0;
            status_reg  <= gms_pkg::ST_OK;
            state_reg   <= gms_pkg::GS_IDLE;
            goal_reg    <= '0;
            start_reg   <= '0;
            width_reg   <= '0;
            force_reg   <= '0;
            elapsed_reg <= '0;
            dist_reg    <= '0;
            step_reg    <= '0;
            prog_reg    <= '0;
            rem_reg     <= '0;
            down_reg    <= 1'b0;
        end
        else if (advance)
        begin
            estop_reg   <= estop_next;
            homed_reg   <= homed_next;
            nopart_reg  <= nopart_next;
            moving_reg  <= moving_next;
            status_reg  <= status_next;
            state_reg   <= state_next;
            goal_reg    <= goal_next;
            start_reg   <= start_next;
            width_reg   <= width_next;
            force_reg   <= force_next;
            elapsed_reg <= elapsed_next;
            dist_reg    <= dist_next;
            step_reg    <= step_next;
            prog_reg    <= prog_next;
            rem_reg     <= rem_next;
            down_reg    <= down_next;
        end
    end

endmodule
